/* rtl/aluf_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// aluf_pkg: shared types and constants
// Request and result payloads, request and status codes, controller state
// and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package aluf_pkg;

	localparam int MAX_ENTRIES = 64;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

	typedef enum logic [1:0] {
		REQ_APPEND = 2'd0,
		REQ_LIST   = 2'd1,
		REQ_UNIQUE = 2'd2
	} req_kind_t;

	typedef enum logic [2:0] {
		ST_LISTED    = 3'd0,
		ST_APPENDED  = 3'd1,
		ST_FULL      = 3'd2,
		ST_EMPTY     = 3'd3,
		ST_NO_UNIQUE = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SWEEP,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic [1:0]         req_type;
		logic signed [15:0] value;
	} aluf_req_t;

	typedef struct packed {
		logic signed [15:0] item;
		logic [2:0]         status;
		logic               last;
	} aluf_res_t;

	typedef struct packed {
		logic    take;
		logic    sweep_start;
		logic    imm_emit;
		status_t imm_status;
		logic    finish;
	} aluf_cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic out_busy;
		logic out_free;
		logic sweep_done;
	} aluf_stat_t;

endpackage
`default_nettype wire

/* rtl/aluf_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// aluf_ctrl: request sequencer
// Accepts requests, issues immediate results, starts store sweeps and
// triggers the closing step of each request.
// ----------------------------------------------------------------------------
module aluf_ctrl
	import aluf_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	input  wire logic [1:0] req_type,
	output logic            req_stall,
	input  wire aluf_stat_t stat,
	output aluf_cmd_t       cmd
);

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign req_stall = (state_q != S_IDLE) || stat.out_busy;
	assign accept    = req_valid && !req_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req_type) inside
						REQ_APPEND: begin
							if (!stat.full) begin
								state_d = stat.empty ? S_FINISH : S_SWEEP;
							end
						end
						REQ_LIST, REQ_UNIQUE: begin
							if (!stat.empty) begin
								state_d = S_SWEEP;
							end
						end
						default: ;
					endcase
				end
			end
			S_SWEEP: begin
				if (stat.sweep_done) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (stat.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.imm_status = ST_LISTED;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.take = 1'b1;
					case (req_type) inside
						REQ_APPEND: begin
							if (stat.full) begin
								cmd.imm_emit   = 1'b1;
								cmd.imm_status = ST_FULL;
							end else if (!stat.empty) begin
								cmd.sweep_start = 1'b1;
							end
						end
						REQ_LIST, REQ_UNIQUE: begin
							if (stat.empty) begin
								cmd.imm_emit   = 1'b1;
								cmd.imm_status = ST_EMPTY;
							end else begin
								cmd.sweep_start = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
			S_SWEEP: ;
			S_FINISH: cmd.finish = stat.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

/* rtl/aluf_dpath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// aluf_dpath: store and sweep datapath
// Value memory with one read port, duplicate flags, sweep read pipeline,
// held candidate for the last-mark and the result register.
// ----------------------------------------------------------------------------
module aluf_dpath
	import aluf_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire aluf_req_t req,
	input  wire aluf_cmd_t cmd,
	output aluf_stat_t     stat,
	output logic           res_valid,
	input  wire logic      res_stall,
	output aluf_res_t      res
);

	logic [15:0]            mem_q [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] dup_q;
	logic [CNT_W-1:0]       fill_q;
	logic [CNT_W-1:0]       iss_idx_q;
	logic                   sweep_q;
	logic                   pend_s1;
	logic [IDX_W-1:0]       idx_s1;
	logic [15:0]            rdata_s1;
	logic                   dup_s1;
	logic                   match_q;
	logic                   cand_val_q;
	logic [15:0]            cand_q;
	req_kind_t              req_q;
	logic [15:0]            val_q;
	logic                   out_valid_q;
	aluf_res_t              out_q;

	logic      is_append;
	logic      keep;
	logic      out_free;
	logic      consume;
	logic      iss_more;
	logic      issue;
	logic      hit;
	logic      out_load;
	aluf_res_t out_d;

	assign is_append = (req_q == REQ_APPEND);
	assign keep      = (req_q == REQ_LIST) || !dup_s1;
	assign out_free  = !out_valid_q || !res_stall;
	// drop or buffer a read entry; an emit of the held candidate needs a free slot
	assign consume   = pend_s1 && (is_append || !keep || !cand_val_q || out_free);
	assign iss_more  = (iss_idx_q < fill_q);
	assign issue     = sweep_q && iss_more && (!pend_s1 || consume);
	assign hit       = (rdata_s1 == val_q);

	always_comb begin
		out_load    = 1'b0;
		out_d.item  = '0;
		out_d.status = ST_LISTED;
		out_d.last  = 1'b1;
		if (cmd.imm_emit) begin
			out_load     = 1'b1;
			out_d.status = cmd.imm_status;
		end else if (cmd.finish) begin
			out_load = 1'b1;
			if (is_append) begin
				out_d.status = ST_APPENDED;
			end else if (cand_val_q) begin
				out_d.item = cand_q;
			end else begin
				out_d.status = ST_NO_UNIQUE;
			end
		end else if (pend_s1 && !is_append && keep && cand_val_q && out_free) begin
			out_load   = 1'b1;
			out_d.item = cand_q;
			out_d.last = 1'b0;
		end
	end

	always_comb begin
		stat.empty      = (fill_q == '0);
		stat.full       = (fill_q == CNT_W'(MAX_ENTRIES));
		stat.out_busy   = out_valid_q;
		stat.out_free   = out_free;
		stat.sweep_done = sweep_q && !iss_more && !pend_s1;
	end

	// memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (cmd.finish && is_append) begin
			mem_q[fill_q[IDX_W-1:0]] <= val_q;
		end
		if (issue) begin
			rdata_s1 <= mem_q[iss_idx_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			iss_idx_q   <= '0;
			sweep_q     <= 1'b0;
			pend_s1     <= 1'b0;
			match_q     <= 1'b0;
			cand_val_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.sweep_start) begin
				iss_idx_q <= '0;
				sweep_q   <= 1'b1;
			end else begin
				if (issue) begin
					iss_idx_q <= iss_idx_q + CNT_W'(1);
				end
				if (stat.sweep_done) begin
					sweep_q <= 1'b0;
				end
			end
			if (issue) begin
				pend_s1 <= 1'b1;
			end else if (consume) begin
				pend_s1 <= 1'b0;
			end
			if (consume && is_append && hit) begin
				match_q <= 1'b1;
			end
			if (consume && !is_append && keep) begin
				cand_val_q <= 1'b1;
			end
			if (cmd.finish) begin
				cand_val_q <= 1'b0;
				if (is_append) begin
					fill_q  <= fill_q + CNT_W'(1);
					match_q <= 1'b0;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!res_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			req_q <= req_kind_t'(req.req_type);
			val_q <= req.value;
		end
		// the duplicate flag travels with the read value
		if (issue) begin
			idx_s1 <= iss_idx_q[IDX_W-1:0];
			dup_s1 <= dup_q[iss_idx_q[IDX_W-1:0]];
		end
		// both copies of a repeated value get marked
		if (consume && is_append && hit) begin
			dup_q[idx_s1] <= 1'b1;
		end
		if (cmd.finish && is_append) begin
			dup_q[fill_q[IDX_W-1:0]] <= match_q;
		end
		if (consume && !is_append && keep) begin
			cand_q <= rdata_s1;
		end
		if (out_load) begin
			out_q <= out_d;
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

endmodule
`default_nettype wire

/* rtl/append_list_unique_filter.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// append_list_unique_filter: ordered value store with list and unique filter
// Appends signed 16-bit values to a bounded store, lists all of them, or
// lists only the values that occur exactly once, in insertion order.
// ----------------------------------------------------------------------------
//
//  channel  | signals                 | moves
//  ---------+-------------------------+------------------------------------
//  request  | req_valid, req_stall    | req_type, value (one transfer each)
//  result   | res_valid, res_stall    | item, status, last
//
//  An append to a full store or a list or unique request on an empty one
//  answers in the cycle after the transfer, an append to an empty store
//  after a pass through the finish state; any other append, list or unique
//  request sweeps the n stored values through the single read port of the
//  value memory, one listed value per cycle while the result side does not
//  stall. Reset clears the fill count and all control; stored values need none.
//  A stall on the result side holds the sweep; a new request waits until
//  the previous request's final result has been taken.
//
module append_list_unique_filter
	import aluf_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_stall,
	input  wire aluf_req_t req,
	output logic           res_valid,
	input  wire logic      res_stall,
	output aluf_res_t      res
);

	aluf_cmd_t  cmd;
	aluf_stat_t stat;

	// sequencer: decide per request between an immediate answer and a sweep
	aluf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_type  (req.req_type),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// datapath: store, duplicate flags, sweep pipeline and result register;
	// each listed value is held until the next one is found so that the
	// final one can carry last
	aluf_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.stat      (stat),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

`ifndef SYNTHESIS
	// accept a request only with the result side drained
	a_accept_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |-> !res_valid)
		else $error("request accepted while a result is pending");

	// every status result closes its request
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (res.status != ST_LISTED)) |-> res.last)
		else $error("status result without last");

	// status results carry a zero item
	a_status_item: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (res.status != ST_LISTED)) |-> (res.item == 16'sd0))
		else $error("status result with nonzero item");
`endif

endmodule
`default_nettype wire

/* tb/append_list_unique_filter_chk.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// append_list_unique_filter_chk: result checker for the value store
// Keeps a shadow copy of the store from every accepted request transfer,
// queues the results each request must cause, and compares each accepted
// result transfer field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module append_list_unique_filter_chk
	import aluf_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	input  wire logic      req_stall,
	input  wire aluf_req_t req,
	input  wire logic      res_valid,
	input  wire logic      res_stall,
	input  wire aluf_res_t res,
	output int             errors,
	output int             outstanding
);

	localparam int REPORT_LIMIT = 10;

	logic [15:0] shadow_vals [MAX_ENTRIES];
	int          shadow_fill;
	aluf_res_t   expected_res [$];

	function automatic aluf_res_t make_res(logic [15:0] v, status_t st, logic lst);
		aluf_res_t r;
		r.item   = v;
		r.status = st;
		r.last   = lst;
		return r;
	endfunction

	// Equality is on the raw 16-bit pattern.
	function automatic bit is_single(int idx);
		int hits;
		hits = 0;
		for (int j = 0; j < shadow_fill; j++)
			if (shadow_vals[j] == shadow_vals[idx])
				hits++;
		return hits == 1;
	endfunction

	function automatic void predict_request(aluf_req_t r);
		int final_idx;
		final_idx = -1;
		case (r.req_type)
			REQ_APPEND: begin
				if (shadow_fill < MAX_ENTRIES) begin
					shadow_vals[shadow_fill] = r.value;
					shadow_fill++;
					expected_res.push_back(make_res('0, ST_APPENDED, 1'b1));
				end else begin
					expected_res.push_back(make_res('0, ST_FULL, 1'b1));
				end
			end
			REQ_LIST, REQ_UNIQUE: begin
				if (shadow_fill == 0) begin
					expected_res.push_back(make_res('0, ST_EMPTY, 1'b1));
				end else begin
					// find the final listed slot first so it can carry last
					for (int i = 0; i < shadow_fill; i++)
						if (r.req_type == REQ_LIST || is_single(i))
							final_idx = i;
					if (final_idx < 0)
						expected_res.push_back(make_res('0, ST_NO_UNIQUE, 1'b1));
					else
						for (int i = 0; i <= final_idx; i++)
							if (r.req_type == REQ_LIST || is_single(i))
								expected_res.push_back(make_res(shadow_vals[i], ST_LISTED,
									i == final_idx));
				end
			end
			default: ; // unused request code: no state change, no result
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		aluf_res_t want;
		if (!arst_n) begin
			shadow_fill = 0;
			expected_res.delete();
			outstanding = 0;
		end else begin
			if (req_valid && !req_stall)
				predict_request(req);
			if (res_valid && !res_stall) begin
				if (expected_res.size() == 0) begin
					errors++;
					if (errors <= REPORT_LIMIT)
						$display("%0t: result with nothing expected: item %0d status %0d last %0d",
							$realtime, res.item, res.status, res.last);
				end else begin
					want = expected_res.pop_front();
					if (res.item !== want.item || res.status !== want.status ||
					    res.last !== want.last) begin
						errors++;
						if (errors <= REPORT_LIMIT)
							$display("%0t: result mismatch: item %0d/%0d status %0d/%0d last %0d/%0d (expected/actual)",
								$realtime, want.item, res.item, want.status, res.status,
								want.last, res.last);
					end
				end
			end
			outstanding = expected_res.size();
		end
	end

endmodule

/* tb/append_list_unique_filter_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// append_list_unique_filter_tb: stimulus and verdict for the value store
// Drives directed and random append, list and unique requests with random
// gaps and result-side stalls, and lets the checker beside the block
// predict and compare every result.
// ----------------------------------------------------------------------------
module append_list_unique_filter_tb
	import aluf_pkg::*;
();

	// code 3 has no member in the request enum; the block ignores it
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	localparam int RANDOM_ITEMS     = 300;
	localparam int LONG_HOLD_CYCLES = 400;
	// a full sweep plus pipeline and output slack
	localparam int DRAIN_CYCLES     = MAX_ENTRIES + 16;

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_stall;
	aluf_req_t req;
	logic      res_valid;
	logic      res_stall;
	aluf_res_t res;

	int chk_errors;
	int outstanding;

	// set by the sender, consumed once by the receiver for its long hold-off
	bit          long_hold_req;
	logic [15:0] value_pool [8];
	int          appends_sent;
	int          items_sent;

	append_list_unique_filter u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	append_list_unique_filter_chk u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.res         (res),
		.errors      (chk_errors),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop well beyond the slowest legal run: every request listing a
	// full store with each result held by the longest random stall.
	initial begin
		#100_000_000;
		$display("append_list_unique_filter_tb NOT OK");
		$finish;
	end

	// Sender gap: mostly back to back or short, now and then long. Every fifth
	// block of twenty requests runs with no gaps at all.
	function automatic int sender_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (((items_sent / 20) % 5) == 4)
			return 0;
		if (roll < 50)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(30, 80);
	endfunction

	// Draw from a small pool so the store builds up repeats, mixed with the
	// edges of the signed range and fully random patterns.
	function automatic logic [15:0] pick_value();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 45)
			return value_pool[$urandom_range(0, 7)];
		if (roll < 55) begin
			case ($urandom_range(0, 3))
				0:       return 16'h8000;
				1:       return 16'h7fff;
				2:       return 16'h0000;
				default: return 16'hffff;
			endcase
		end
		return 16'($urandom);
	endfunction

	function automatic logic [1:0] pick_kind();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 45)
			return REQ_APPEND;
		if (roll < 67)
			return REQ_LIST;
		if (roll < 90)
			return REQ_UNIQUE;
		return REQ_UNUSED;
	endfunction

	// Enter and leave at a falling edge. Hold the payload until the transfer
	// and keep valid high across back-to-back transfers.
	task automatic send_req(input logic [1:0] kind, input logic [15:0] val);
		int gap;
		gap = sender_gap();
		if (gap > 0) begin
			req_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid    = 1'b1;
		req.req_type = kind;
		req.value    = val;
		do
			@(posedge clk);
		while (req_stall);
		items_sent++;
		if (kind == REQ_APPEND)
			appends_sent++;
		@(negedge clk);
	endtask

	// Drop valid and wait for every queued result, then let the block settle.
	task automatic wait_drained();
		req_valid = 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Result side: alternate free runs and stall bursts. Take the long
	// hold-off once, when the sender asks for it, so the block backs up.
	initial begin
		int  run_len;
		int  stall_len;
		int  roll;
		bit  hold_done;
		res_stall = 1'b0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			roll    = $urandom_range(0, 99);
			run_len = (roll < 10) ? $urandom_range(100, 200) : $urandom_range(1, 8);
			@(negedge clk);
			res_stall = 1'b0;
			repeat (run_len - 1) @(negedge clk);
			roll = $urandom_range(0, 99);
			if (long_hold_req && !hold_done) begin
				stall_len = LONG_HOLD_CYCLES;
				hold_done = 1'b1;
			end else if (roll < 60) begin
				stall_len = $urandom_range(1, 2);
			end else if (roll < 92) begin
				stall_len = $urandom_range(3, 10);
			end else begin
				stall_len = $urandom_range(30, 90);
			end
			@(negedge clk);
			res_stall = 1'b1;
			repeat (stall_len - 1) @(negedge clk);
		end
	end

	initial begin
		arst_n        = 1'b0;
		req_valid     = 1'b0;
		req           = '0;
		long_hold_req = 1'b0;
		appends_sent  = 0;
		items_sent    = 0;
		foreach (value_pool[k])
			value_pool[k] = 16'($urandom);
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// Directed: empty store, ignored code, a store with no single value,
		// the signed extremes, and a duplicate that knocks a value out.
		send_req(REQ_LIST, 16'($urandom));
		send_req(REQ_UNIQUE, 16'($urandom));
		send_req(REQ_UNUSED, 16'hffff);
		send_req(REQ_APPEND, 16'h8000);
		send_req(REQ_APPEND, 16'h8000);
		send_req(REQ_UNIQUE, 16'h0000);
		send_req(REQ_LIST, 16'hffff);
		send_req(REQ_APPEND, 16'h7fff);
		send_req(REQ_APPEND, 16'h0000);
		send_req(REQ_APPEND, 16'hffff);
		send_req(REQ_APPEND, 16'h0001);
		send_req(REQ_UNIQUE, 16'h5555);
		send_req(REQ_APPEND, 16'h0000);
		send_req(REQ_UNIQUE, 16'haaaa);
		send_req(REQ_LIST, 16'h5555);
		send_req(REQ_UNUSED, 16'h7fff);
		send_req(REQ_LIST, 16'haaaa);

		// Random mix. Ask for the long result hold-off partway in while the
		// sender keeps offering, and later pause until the block drains.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 100)
				long_hold_req = 1'b1;
			if (n == 200)
				wait_drained();
			send_req(pick_kind(), pick_value());
		end

		// Make sure the store has filled and appends get dropped, then list
		// and filter the full store.
		while (appends_sent < MAX_ENTRIES + 4)
			send_req(REQ_APPEND, pick_value());
		send_req(REQ_LIST, 16'($urandom));
		send_req(REQ_UNIQUE, 16'($urandom));

		wait_drained();
		if (chk_errors == 0 && outstanding == 0)
			$display("append_list_unique_filter_tb OK");
		else
			$display("append_list_unique_filter_tb NOT OK");
		$finish;
	end

endmodule
